// File: design/mwt_pkg.sv
// Shared types and constants for the memory watchpoint table.
// Used by the controller, the datapath and the top level; depends on nothing.
package mwt_pkg;

    localparam int MAX_WP = 16;
    localparam int IDX_W  = (MAX_WP > 1) ? $clog2(MAX_WP) : 1;
    localparam int CNT_W  = $clog2(MAX_WP + 1);

    localparam int OP_W    = 3;
    localparam int ADDR_W  = 32;
    localparam int FLAGS_W = 5;
    localparam int SIZE_W  = 4;
    localparam int STAT_W  = 2;
    localparam int MIDX_W  = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK  = 3'd4;
    localparam logic [OP_W-1:0] OP_PAGE   = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // entry flag bit positions
    localparam int FL_EN  = 0;
    localparam int FL_RD  = 1;
    localparam int FL_WR  = 2;
    localparam int FL_LOG = 3;
    localparam int FL_BRK = 4;

    typedef struct packed {
        logic load_in;
        logic scan;
        logic exec;
        logic shift;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic in_scan_op;
        logic empty;
        logic hit;
        logic at_last;
        logic need_shift;
        logic shift_done;
    } dp_status_t;

endpackage

// File: design/memory_watchpoint_table.sv
// Flow: an accepted transaction scans the table up to its first hit (skipped for an empty
// table or an operation that needs no scan), executes, moves up the entries above a removed
// one and loads the output register. One transaction at a time; the next can be taken the
// cycle after the result is loaded. The scan walks the table one entry per cycle through its
// single read port. Reset (aresetn low, synchronous) empties the table, clears m_valid and
// returns the controller to idle; entry contents are not cleared.
module memory_watchpoint_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mwt_pkg::OP_W-1:0]      s_operation,
    input  logic [mwt_pkg::ADDR_W-1:0]    s_address,
    input  logic [mwt_pkg::ADDR_W-1:0]    s_end_address,
    input  logic                          s_new_enabled,
    input  logic                          s_new_watch_read,
    input  logic                          s_new_watch_write,
    input  logic                          s_new_log_on_hit,
    input  logic                          s_new_break_on_hit,
    input  logic [mwt_pkg::SIZE_W-1:0]    s_access_size,
    input  logic                          s_access_is_write,
    input  logic [mwt_pkg::ADDR_W-1:0]    s_page_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mwt_pkg::STAT_W-1:0]    m_status,
    output logic                          m_matched,
    output logic [mwt_pkg::MIDX_W-1:0]    m_matched_index,
    output logic                          m_break_now,
    output logic                          m_log_now,
    output logic                          m_page_overlaps
);
    import mwt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    mwt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mwt_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_operation        (s_operation),
        .s_address          (s_address),
        .s_end_address      (s_end_address),
        .s_new_enabled      (s_new_enabled),
        .s_new_watch_read   (s_new_watch_read),
        .s_new_watch_write  (s_new_watch_write),
        .s_new_log_on_hit   (s_new_log_on_hit),
        .s_new_break_on_hit (s_new_break_on_hit),
        .s_access_size      (s_access_size),
        .s_access_is_write  (s_access_is_write),
        .s_page_length      (s_page_length),
        .m_status           (m_status),
        .m_matched          (m_matched),
        .m_matched_index    (m_matched_index),
        .m_break_now        (m_break_now),
        .m_log_now          (m_log_now),
        .m_page_overlaps    (m_page_overlaps)
    );

endmodule

// File: design/mwt_ctrl.sv
// Sequencer of the watchpoint table: accept, scan, execute, compact, respond.
// Depends on mwt_pkg; drives the datapath through dp_cmd_t.
module mwt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  mwt_pkg::dp_status_t sts,
    output mwt_pkg::dp_cmd_t    cmd
);
    import mwt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = (sts.in_scan_op && !sts.empty) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.at_last) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.need_shift ? S_SHIFT : S_RESP;
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (sts.shift_done) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: design/mwt_datapath.sv
// Entry storage, range comparators, result and output registers.
// Depends on mwt_pkg; steered by mwt_ctrl through dp_cmd_t.
module mwt_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mwt_pkg::dp_cmd_t              cmd,
    output mwt_pkg::dp_status_t           sts,
    input  logic [mwt_pkg::OP_W-1:0]      s_operation,
    input  logic [mwt_pkg::ADDR_W-1:0]    s_address,
    input  logic [mwt_pkg::ADDR_W-1:0]    s_end_address,
    input  logic                          s_new_enabled,
    input  logic                          s_new_watch_read,
    input  logic                          s_new_watch_write,
    input  logic                          s_new_log_on_hit,
    input  logic                          s_new_break_on_hit,
    input  logic [mwt_pkg::SIZE_W-1:0]    s_access_size,
    input  logic                          s_access_is_write,
    input  logic [mwt_pkg::ADDR_W-1:0]    s_page_length,
    output logic [mwt_pkg::STAT_W-1:0]    m_status,
    output logic                          m_matched,
    output logic [mwt_pkg::MIDX_W-1:0]    m_matched_index,
    output logic                          m_break_now,
    output logic                          m_log_now,
    output logic                          m_page_overlaps
);
    import mwt_pkg::*;

    // entry table
    logic [ADDR_W-1:0]  start_mem [MAX_WP];
    logic [ADDR_W-1:0]  end_mem   [MAX_WP];
    logic [FLAGS_W-1:0] flags_mem [MAX_WP];

    // latched transaction
    logic [OP_W-1:0]    op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  end_reg;
    logic [FLAGS_W-1:0] nflags_reg;
    logic               wr_reg;
    logic [ADDR_W-1:0]  last_reg;
    logic [ADDR_W-1:0]  suf_reg;
    logic [ADDR_W-1:0]  pend_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               found_reg;
    logic [FLAGS_W-1:0] hit_flags_reg;

    logic [STAT_W-1:0]  res_status_reg;
    logic               res_matched_reg;
    logic [MIDX_W-1:0]  res_midx_reg;
    logic               res_brk_reg;
    logic               res_log_reg;
    logic               res_pov_reg;

    logic [STAT_W-1:0]  m_status_reg;
    logic               m_matched_reg;
    logic [MIDX_W-1:0]  m_midx_reg;
    logic               m_brk_reg;
    logic               m_log_reg;
    logic               m_pov_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   count_idx;
    logic [ADDR_W-1:0]  rd_start;
    logic [ADDR_W-1:0]  rd_end;
    logic [FLAGS_W-1:0] rd_flags;
    logic [ADDR_W-1:0]  s_or;
    logic [ADDR_W-1:0]  e_or;
    logic [ADDR_W-1:0]  page_mask_in;
    logic               start_eq;
    logic               overlap;
    logic               page_hit;
    logic               hit;
    logic               at_last;
    logic               full;
    logic               dir_ok;

    // compaction reads the entry above the one being written
    assign rd_addr   = cmd.shift ? (idx_reg + IDX_W'(1)) : idx_reg;
    assign count_idx = IDX_W'(count_reg);
    assign rd_start  = start_mem[rd_addr];
    assign rd_end    = end_mem[rd_addr];
    assign rd_flags  = flags_mem[rd_addr];

    assign s_or     = rd_start | suf_reg;
    assign e_or     = rd_end | suf_reg;
    assign start_eq = (rd_start == addr_reg);
    assign overlap  = (rd_end >= addr_reg) && (last_reg >= rd_start);
    assign page_hit = (s_or == pend_reg) || (e_or == pend_reg) ||
                      ((s_or < pend_reg) && (e_or > pend_reg));

    always_comb begin
        case (op_reg) inside
            OP_ADD, OP_REMOVE, OP_TOGGLE: hit = start_eq;
            OP_CHECK:                     hit = overlap;
            OP_PAGE:                      hit = page_hit;
            default:                      hit = 1'b0;
        endcase
    end

    assign at_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign full    = (count_reg >= CNT_W'(MAX_WP));
    assign dir_ok  = hit_flags_reg[FL_EN] &&
                     (wr_reg ? hit_flags_reg[FL_WR] : hit_flags_reg[FL_RD]);
    assign page_mask_in = s_page_length - ADDR_W'(1);

    always_comb begin
        sts            = '0;
        sts.in_scan_op = (s_operation == OP_ADD) || (s_operation == OP_REMOVE) ||
                         (s_operation == OP_TOGGLE) || (s_operation == OP_CHECK) ||
                         (s_operation == OP_PAGE);
        sts.empty      = (count_reg == '0);
        sts.hit        = hit;
        sts.at_last    = at_last;
        sts.need_shift = (op_reg == OP_REMOVE) && found_reg && !at_last;
        sts.shift_done = ((CNT_W'(idx_reg) + CNT_W'(2)) >= count_reg);
    end

    // entry count: the only state that reset clears
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            if (cmd.exec) begin
                case (op_reg)
                    OP_ADD: begin
                        if (!found_reg && !full) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                    OP_REMOVE: begin
                        if (found_reg && at_last) begin
                            count_reg <= count_reg - CNT_W'(1);
                        end
                    end
                    OP_CLEAR: count_reg <= '0;
                    default: ;
                endcase
            end
            if (cmd.shift && sts.shift_done) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // table writes
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            case (op_reg)
                OP_ADD: begin
                    if (found_reg) begin
                        end_mem[idx_reg]   <= end_reg;
                        flags_mem[idx_reg] <= {nflags_reg[FLAGS_W-1:1], rd_flags[FL_EN]};
                    end else if (!full) begin
                        start_mem[count_idx] <= addr_reg;
                        end_mem[count_idx]   <= end_reg;
                        flags_mem[count_idx] <= nflags_reg;
                    end
                end
                OP_TOGGLE: begin
                    if (found_reg) begin
                        flags_mem[idx_reg] <= rd_flags ^ FLAGS_W'(1 << FL_EN);
                    end
                end
                default: ;
            endcase
        end
        if (cmd.shift) begin
            start_mem[idx_reg] <= rd_start;
            end_mem[idx_reg]   <= rd_end;
            flags_mem[idx_reg] <= rd_flags;
        end
    end

    // transaction, scan and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg     <= s_operation;
            addr_reg   <= s_address;
            end_reg    <= s_end_address;
            nflags_reg <= {s_new_break_on_hit, s_new_log_on_hit, s_new_watch_write,
                           s_new_watch_read, s_new_enabled};
            wr_reg     <= s_access_is_write;
            last_reg   <= s_address + ADDR_W'(s_access_size) - ADDR_W'(1);
            suf_reg    <= page_mask_in;
            pend_reg   <= s_address | page_mask_in;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
        end
        if (cmd.scan) begin
            if (hit) begin
                found_reg     <= 1'b1;
                hit_flags_reg <= rd_flags;
            end else if (!at_last) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
        if (cmd.shift) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.exec) begin
            res_status_reg  <= ST_OK;
            res_matched_reg <= 1'b0;
            res_midx_reg    <= '0;
            res_brk_reg     <= 1'b0;
            res_log_reg     <= 1'b0;
            res_pov_reg     <= 1'b0;
            case (op_reg)
                OP_ADD: begin
                    if (!found_reg && full) begin
                        res_status_reg <= ST_FULL;
                    end
                end
                OP_REMOVE, OP_TOGGLE: begin
                    if (!found_reg) begin
                        res_status_reg <= ST_NOT_FOUND;
                    end
                end
                OP_CHECK: begin
                    if (found_reg) begin
                        res_matched_reg <= 1'b1;
                        res_midx_reg    <= MIDX_W'(idx_reg);
                        res_brk_reg     <= dir_ok && hit_flags_reg[FL_BRK];
                        res_log_reg     <= dir_ok && hit_flags_reg[FL_LOG];
                    end
                end
                OP_PAGE: res_pov_reg <= found_reg;
                default: ;
            endcase
        end
        if (cmd.load_out) begin
            m_status_reg  <= res_status_reg;
            m_matched_reg <= res_matched_reg;
            m_midx_reg    <= res_midx_reg;
            m_brk_reg     <= res_brk_reg;
            m_log_reg     <= res_log_reg;
            m_pov_reg     <= res_pov_reg;
        end
    end

    assign m_status        = m_status_reg;
    assign m_matched       = m_matched_reg;
    assign m_matched_index = m_midx_reg;
    assign m_break_now     = m_brk_reg;
    assign m_log_now       = m_log_reg;
    assign m_page_overlaps = m_pov_reg;

endmodule

// File: design/mwt_checker.sv
// Port-level checks for memory_watchpoint_table, attached by bind.
// Depends on mwt_pkg for field widths and status codes.
module mwt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mwt_pkg::STAT_W-1:0]    m_status,
    input logic                          m_matched,
    input logic [mwt_pkg::MIDX_W-1:0]    m_matched_index,
    input logic                          m_break_now,
    input logic                          m_log_now,
    input logic                          m_page_overlaps
);
    import mwt_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_matched)
            && $stable(m_page_overlaps))
        else $error("result changed while stalled");

    // one transaction in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is in progress");

    // error status only comes from table updates, never with query results
    a_status_no_query: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> !m_matched && !m_page_overlaps)
        else $error("error status alongside a query result");

    // break, log and index are only reported for a match
    a_nomatch_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_matched |-> !m_break_now && !m_log_now && (m_matched_index == '0))
        else $error("match fields set without a match");

    // an access check and a page query never answer together
    a_query_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_matched |-> !m_page_overlaps)
        else $error("access match and page overlap in one result");

endmodule

bind memory_watchpoint_table mwt_checker u_mwt_checker (.*);

// File: sim/tb_memory_watchpoint_table.sv
// Self-checking testbench for the memory watchpoint table: valid/ready driver and monitor,
// with an in-bench predictor of the range table and a queue of predicted results.
// Depends on mwt_pkg and memory_watchpoint_table only.
module tb_memory_watchpoint_table;
    timeunit 1ns;
    timeprecision 1ps;

    import mwt_pkg::*;

    // operation codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam logic [FLAGS_W-1:0] F_EN  = FLAGS_W'(1) << FL_EN;
    localparam logic [FLAGS_W-1:0] F_RD  = FLAGS_W'(1) << FL_RD;
    localparam logic [FLAGS_W-1:0] F_WR  = FLAGS_W'(1) << FL_WR;
    localparam logic [FLAGS_W-1:0] F_LOG = FLAGS_W'(1) << FL_LOG;
    localparam logic [FLAGS_W-1:0] F_BRK = FLAGS_W'(1) << FL_BRK;
    localparam logic [FLAGS_W-1:0] F_ALL = '1;

    localparam int RANDOM_CMDS = 550;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  last_addr;
        logic [FLAGS_W-1:0] flags;
        logic [SIZE_W-1:0]  size;
        logic               is_write;
        logic [ADDR_W-1:0]  page_len;
    } wp_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              matched;
        logic [MIDX_W-1:0] idx;
        logic              brk;
        logic              lg;
        logic              pov;
    } wp_verdict_t;

    logic                aclk              = 1'b0;
    logic                aresetn           = 1'b0;
    logic                s_valid           = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation       = '0;
    logic [ADDR_W-1:0]   s_address         = '0;
    logic [ADDR_W-1:0]   s_end_address     = '0;
    logic                s_new_enabled     = 1'b0;
    logic                s_new_watch_read  = 1'b0;
    logic                s_new_watch_write = 1'b0;
    logic                s_new_log_on_hit  = 1'b0;
    logic                s_new_break_on_hit = 1'b0;
    logic [SIZE_W-1:0]   s_access_size     = '0;
    logic                s_access_is_write = 1'b0;
    logic [ADDR_W-1:0]   s_page_length     = '0;
    logic                m_valid;
    logic                m_ready           = 1'b0;
    logic [STAT_W-1:0]   m_status;
    logic                m_matched;
    logic [MIDX_W-1:0]   m_matched_index;
    logic                m_break_now;
    logic                m_log_now;
    logic                m_page_overlaps;

    // predictor copy of the table
    logic [ADDR_W-1:0]  tbl_start [MAX_WP];
    logic [ADDR_W-1:0]  tbl_end   [MAX_WP];
    logic [FLAGS_W-1:0] tbl_flags [MAX_WP];
    int                 tbl_count = 0;

    wp_cmd_t     stim_q[$];
    wp_verdict_t verdict_q[$];
    logic [ADDR_W-1:0] start_pool[$];

    int  n_queued       = 0;
    int  total_cmds     = 0;
    int  accepted_count = 0;
    int  mismatches     = 0;
    int  op_seen [8]    = '{default: 0};
    int  n_full = 0, n_absent = 0, n_hits = 0, n_overlap = 0;
    logic hold_off      = 1'b0;

    memory_watchpoint_table i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_address          (s_address),
        .s_end_address      (s_end_address),
        .s_new_enabled      (s_new_enabled),
        .s_new_watch_read   (s_new_watch_read),
        .s_new_watch_write  (s_new_watch_write),
        .s_new_log_on_hit   (s_new_log_on_hit),
        .s_new_break_on_hit (s_new_break_on_hit),
        .s_access_size      (s_access_size),
        .s_access_is_write  (s_access_is_write),
        .s_page_length      (s_page_length),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_matched          (m_matched),
        .m_matched_index    (m_matched_index),
        .m_break_now        (m_break_now),
        .m_log_now          (m_log_now),
        .m_page_overlaps    (m_page_overlaps)
    );

    always #10 aclk = ~aclk;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Apply one command to the table copy and return the result it should produce.
    function automatic wp_verdict_t predict_verdict(input wp_cmd_t c);
        wp_verdict_t       v;
        int                k;
        int                i;
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] pend;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] e;
        logic [FLAGS_W-1:0] f;
        logic              hit;
        v = '0;
        k = tbl_count;
        for (i = 0; i < tbl_count; i++) begin
            if (tbl_start[i] == c.addr) begin
                k = i;
                break;
            end
        end
        case (c.op)
            OP_ADD: begin
                if (k < tbl_count) begin
                    // replace in place, keep the old enable bit
                    f = c.flags;
                    f[FL_EN] = tbl_flags[k][FL_EN];
                    tbl_end[k]   = c.last_addr;
                    tbl_flags[k] = f;
                end else if (tbl_count < MAX_WP) begin
                    tbl_start[tbl_count] = c.addr;
                    tbl_end[tbl_count]   = c.last_addr;
                    tbl_flags[tbl_count] = c.flags;
                    tbl_count++;
                end else begin
                    v.status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (k < tbl_count) begin
                    for (i = k; i + 1 < tbl_count; i++) begin
                        tbl_start[i] = tbl_start[i+1];
                        tbl_end[i]   = tbl_end[i+1];
                        tbl_flags[i] = tbl_flags[i+1];
                    end
                    tbl_count--;
                end else begin
                    v.status = ST_NOT_FOUND;
                end
            end
            OP_TOGGLE: begin
                if (k < tbl_count)
                    tbl_flags[k][FL_EN] = ~tbl_flags[k][FL_EN];
                else
                    v.status = ST_NOT_FOUND;
            end
            OP_CLEAR: tbl_count = 0;
            OP_CHECK: begin
                last = c.addr + ADDR_W'(c.size) - 1;
                for (i = 0; i < tbl_count; i++) begin
                    if (tbl_end[i] >= c.addr && last >= tbl_start[i]) begin
                        f = tbl_flags[i];
                        hit = f[FL_EN] && (c.is_write ? f[FL_WR] : f[FL_RD]);
                        v.matched = 1'b1;
                        v.idx = MIDX_W'(i);
                        v.brk = hit && f[FL_BRK];
                        v.lg  = hit && f[FL_LOG];
                        break;
                    end
                end
            end
            OP_PAGE: begin
                mask = c.page_len - 1;
                pend = c.addr | mask;
                for (i = 0; i < tbl_count; i++) begin
                    s = tbl_start[i] | mask;
                    e = tbl_end[i] | mask;
                    if (s == pend || e == pend || (s < pend && e > pend)) begin
                        v.pov = 1'b1;
                        break;
                    end
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic int idle_pct(input bit rx_side);
        int phase;
        phase = (total_cmds == 0) ? 2 : accepted_count * 3 / total_cmds;
        case (phase)
            0:       return rx_side ? 54 : 21;
            1:       return rx_side ? 21 : 54;
            default: return 0;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return ADDR_W'($urandom_range(0, 16'h3FFF));
        if (r < 7)
            return 32'hFFFF_C000 | ADDR_W'($urandom_range(0, 16'h3FFF));
        return $urandom;
    endfunction

    function automatic logic [ADDR_W-1:0] known_start();
        if (start_pool.size() > 0 && $urandom_range(0, 99) < 85)
            return start_pool[$urandom_range(0, start_pool.size() - 1)];
        return rand_addr();
    endfunction

    // Command with the given key fields; everything else random.
    function automatic wp_cmd_t cmd(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
                                    input logic [ADDR_W-1:0] last,
                                    input logic [FLAGS_W-1:0] fl);
        wp_cmd_t c;
        c.op        = op;
        c.addr      = a;
        c.last_addr = last;
        c.flags     = fl;
        c.size      = SIZE_W'($urandom);
        c.is_write  = 1'($urandom_range(0, 1));
        c.page_len  = $urandom;
        return c;
    endfunction

    function automatic wp_cmd_t random_cmd();
        wp_cmd_t c;
        int      r;
        c = cmd(OP_ADD, rand_addr(), $urandom, FLAGS_W'($urandom));
        r = $urandom_range(0, 99);
        if (r < 25) begin
            if ($urandom_range(0, 3) == 0)
                c.addr = known_start();
            c.last_addr = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom)
                                                     : c.addr + $urandom_range(0, 255);
        end else if (r < 37) begin
            c.op = OP_REMOVE;
            c.addr = known_start();
        end else if (r < 49) begin
            c.op = OP_TOGGLE;
            c.addr = known_start();
        end else if (r < 51) begin
            c.op = OP_CLEAR;
        end else if (r < 81) begin
            c.op = OP_CHECK;
            if ($urandom_range(0, 9) < 6)
                c.addr = known_start() + $urandom_range(0, 16) - 8;
            c.size = ($urandom_range(0, 9) < 8) ? SIZE_W'($urandom_range(1, 8))
                                                : SIZE_W'($urandom_range(0, 15));
        end else if (r < 97) begin
            c.op = OP_PAGE;
            if ($urandom_range(0, 1))
                c.addr = known_start();
            r = $urandom_range(0, 9);
            if (r < 7)
                c.page_len = ADDR_W'(1) << $urandom_range(0, 31);
            else if (r == 9)
                c.page_len = '0;
        end else begin
            c.op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
        end
        return c;
    endfunction

    // Queue a command and track which starts are likely in the table.
    task automatic queue_cmd(input wp_cmd_t c);
        int i;
        stim_q.insert(stim_q.size(), c);
        if (c.op <= OP_PAGE)
            n_queued++;
        case (c.op)
            OP_ADD: begin
                for (i = 0; i < start_pool.size(); i++)
                    if (start_pool[i] == c.addr)
                        break;
                if (i == start_pool.size() && start_pool.size() < 32)
                    start_pool.insert(start_pool.size(), c.addr);
            end
            OP_REMOVE: begin
                for (i = 0; i < start_pool.size(); i++) begin
                    if (start_pool[i] == c.addr) begin
                        start_pool.delete(i);
                        break;
                    end
                end
            end
            OP_CLEAR: start_pool.delete();
            default: ;
        endcase
    endtask

    // driver
    always @(posedge aclk) begin : drive_proc
        wp_cmd_t     cur;
        wp_cmd_t     nxt;
        wp_verdict_t v;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur.op        = s_operation;
                cur.addr      = s_address;
                cur.last_addr = s_end_address;
                cur.flags[FL_EN]  = s_new_enabled;
                cur.flags[FL_RD]  = s_new_watch_read;
                cur.flags[FL_WR]  = s_new_watch_write;
                cur.flags[FL_LOG] = s_new_log_on_hit;
                cur.flags[FL_BRK] = s_new_break_on_hit;
                cur.size      = s_access_size;
                cur.is_write  = s_access_is_write;
                cur.page_len  = s_page_length;
                v = predict_verdict(cur);
                verdict_q.insert(verdict_q.size(), v);
                accepted_count++;
                op_seen[cur.op]++;
                if (v.status == ST_FULL)
                    n_full++;
                if (v.status == ST_NOT_FOUND)
                    n_absent++;
                if (v.matched)
                    n_hits++;
                if (v.pov)
                    n_overlap++;
            end
            if (!s_valid || s_ready) begin
                if (stim_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    nxt = stim_q[0];
                    stim_q.delete(0);
                    s_operation        <= nxt.op;
                    s_address          <= nxt.addr;
                    s_end_address      <= nxt.last_addr;
                    s_new_enabled      <= nxt.flags[FL_EN];
                    s_new_watch_read   <= nxt.flags[FL_RD];
                    s_new_watch_write  <= nxt.flags[FL_WR];
                    s_new_log_on_hit   <= nxt.flags[FL_LOG];
                    s_new_break_on_hit <= nxt.flags[FL_BRK];
                    s_access_size      <= nxt.size;
                    s_access_is_write  <= nxt.is_write;
                    s_page_length      <= nxt.page_len;
                    s_valid            <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : check_proc
        wp_verdict_t got;
        wp_verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_matched, m_matched_index, m_break_now, m_log_now,
                   m_page_overlaps};
            if (verdict_q.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result with nothing outstanding: status %0d", $realtime,
                             got.status);
                mismatches++;
            end else begin
                want = verdict_q[0];
                verdict_q.delete(0);
                if (got.status !== want.status || got.matched !== want.matched ||
                    got.idx !== want.idx || got.brk !== want.brk || got.lg !== want.lg ||
                    got.pov !== want.pov) begin
                    if (mismatches < 10)
                        $display({"%0t: mismatch (exp/got) status %0d/%0d matched %0d/%0d ",
                                  "index %0d/%0d break %0d/%0d log %0d/%0d page %0d/%0d"},
                                 $realtime, want.status, got.status, want.matched,
                                 got.matched, want.idx, got.idx, want.brk, got.brk,
                                 want.lg, got.lg, want.pov, got.pov);
                    mismatches++;
                end
            end
        end
        m_ready <= !hold_off && ($urandom_range(0, 99) >= idle_pct(1'b1));
    end

    // hold the result channel off so the block backs up onto its input
    initial begin
        while (accepted_count < 150)
            @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #(10_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        wp_cmd_t           c;
        logic [ADDR_W-1:0] base;
        int                j;

        // directed: empty table, absent starts, extremes and wrap
        queue_cmd(cmd(OP_PAGE, $urandom, $urandom, '0));
        queue_cmd(cmd(OP_CHECK, 32'h0, '0, '0));
        queue_cmd(cmd(OP_REMOVE, 32'h1234, '0, '0));
        queue_cmd(cmd(OP_TOGGLE, 32'h1234, '0, '0));
        queue_cmd(cmd(OP_ADD, 32'h0, 32'hFFFF_FFFF, F_ALL));
        queue_cmd(cmd(OP_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, F_EN | F_WR | F_BRK));
        queue_cmd(cmd(OP_ADD, 32'h2000, 32'h1000, F_EN | F_RD | F_LOG));
        // rewrite of an existing start must keep its enable bit
        queue_cmd(cmd(OP_ADD, 32'h0, 32'h100, F_ALL & ~F_EN));
        queue_cmd(cmd(OP_TOGGLE, 32'h0, '0, '0));
        c = cmd(OP_CHECK, 32'hFFFF_FFFC, '0, '0);
        c.size = 4'd8;
        c.is_write = 1'b1;
        queue_cmd(c);
        c = cmd(OP_CHECK, 32'h0, '0, '0);
        c.size = 4'd0;
        c.is_write = 1'b0;
        queue_cmd(c);
        c = cmd(OP_CHECK, 32'h1FF8, '0, '0);
        c.size = 4'd15;
        c.is_write = 1'b1;
        queue_cmd(c);
        c = cmd(OP_CHECK, 32'h50, '0, '0);
        c.size = 4'd1;
        c.is_write = 1'b0;
        queue_cmd(c);
        queue_cmd(cmd(OP_TOGGLE, 32'h0, '0, '0));
        queue_cmd(c);
        c = cmd(OP_PAGE, 32'h8000_0000, '0, '0);
        c.page_len = '0;
        queue_cmd(c);
        c = cmd(OP_PAGE, 32'h1234, '0, '0);
        c.page_len = 32'h1000;
        queue_cmd(c);
        c = cmd(OP_PAGE, 32'h1800, '0, '0);
        c.page_len = 32'h300;
        queue_cmd(c);
        c = cmd(OP_PAGE, 32'h9000_0000, '0, '0);
        c.page_len = 32'h8000_0000;
        queue_cmd(c);
        queue_cmd(cmd(OP_RSVD6, $urandom, $urandom, F_ALL));
        queue_cmd(cmd(OP_RSVD7, $urandom, $urandom, F_ALL));
        queue_cmd(cmd(OP_REMOVE, 32'hFFFF_FFF0, '0, '0));
        c = cmd(OP_CHECK, 32'hFFFF_FFF8, '0, '0);
        c.size = 4'd4;
        c.is_write = 1'b1;
        queue_cmd(c);
        queue_cmd(cmd(OP_CLEAR, $urandom, $urandom, '0));
        queue_cmd(cmd(OP_PAGE, 32'h0, '0, '0));

        // random: open with a fill burst, then mixed runs with the odd refill
        j = 0;
        while (n_queued < RANDOM_CMDS) begin
            if (j == 0 || $urandom_range(0, 19) == 0) begin
                base = rand_addr() & ~ADDR_W'(32'h3FF);
                queue_cmd(cmd(OP_CLEAR, $urandom, $urandom, '0));
                for (int n = 0; n <= MAX_WP; n++)
                    queue_cmd(cmd(OP_ADD, base + n * 32'h40,
                                  base + n * 32'h40 + $urandom_range(0, 63),
                                  FLAGS_W'($urandom)));
                repeat (4) begin
                    c = cmd(OP_CHECK, base + $urandom_range(0, 32'h480), '0, '0);
                    c.size = SIZE_W'($urandom_range(1, 8));
                    queue_cmd(c);
                end
            end else begin
                repeat ($urandom_range(8, 20))
                    queue_cmd(random_cmd());
            end
            j++;
        end
        total_cmds = stim_q.size();

        while (stim_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (verdict_q.size() != 0)
            @(posedge aclk);
        // let any stray result show up
        repeat (60) @(posedge aclk);

        $display({"Ran %0d transactions: %0d add, %0d remove, %0d toggle, %0d clear, ",
                  "%0d check, %0d page, %0d reserved"},
                 accepted_count, op_seen[OP_ADD], op_seen[OP_REMOVE], op_seen[OP_TOGGLE],
                 op_seen[OP_CLEAR], op_seen[OP_CHECK], op_seen[OP_PAGE],
                 op_seen[OP_RSVD6] + op_seen[OP_RSVD7]);
        $display({"Table full %0d, absent start %0d, access hits %0d, ",
                  "page overlaps %0d, mismatches %0d"},
                 n_full, n_absent, n_hits, n_overlap, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
